@@ hdl/hhs_pkg.sv @@
`timescale 1ns / 1ps
package hhs_pkg;
	localparam int CAPACITY = 64;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [2:0] OUT_INCR = 3'd0;
	localparam logic [2:0] OUT_INSERT = 3'd1;
	localparam logic [2:0] OUT_DECR = 3'd2;
	localparam logic [2:0] OUT_READ = 3'd3;
	localparam logic [2:0] OUT_CLEAR = 3'd4;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
	localparam logic [6:0] KEY_LIMIT_RESET = 7'd32;

	typedef struct packed {
		logic [1:0] action;
		logic [63:0] key;
		logic [2:0] value_type;
		logic [5:0] entry_index;
	} hhs_in_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic entry_valid;
		logic [63:0] entry_key;
		logic [31:0] entry_count;
		logic [2:0] entry_type;
		logic [31:0] total_adds;
		logic [6:0] occupancy;
		logic [6:0] freed_entries;
	} hhs_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INS,
		ST_DEC,
		ST_READ,
		ST_CLR,
		ST_DONE
	} hhs_state_t;
endpackage

@@ hdl/hhs_ram.sv @@
`timescale 1ns / 1ps
module hhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/heavy_hitter_summary.sv @@
`timescale 1ns / 1ps
// Misra-Gries frequent-item summary over 64-bit key fingerprints.
// Input beats (in, in_valid, in_stall) carry an action: add a key, read one
// slot by index, or clear the summary. Every action but the undefined fourth
// code gives one result beat on (out, out_valid, out_stall); the undefined
// code is taken and dropped with no result.
// Slot key, count and type live in one synchronous RAM of CAPACITY entries,
// live bits in flip-flops. An add walks the RAM once to look for a match,
// one read per cycle, comparing the registered read data, then writes the hit or
// the new slot. When there is no match and no room, a second walk decrements
// every live slot, one read-modify-write per cycle. A read returns the slot
// at the given index; a clear drops the live bits and zeroes the total and
// the occupancy, leaving the RAM contents as they are.
// One item is in work at a time; in_stall is high from acceptance until the
// result beat has been taken, and the next beat can be taken in the cycle after that.
// While out_stall is high the result holds and no new item is taken.
// Reset empties the table, zeroes the total and sets the key limit to 32; no
// clearing pass is needed. The limit is written and read at APB address 0.
module heavy_hitter_summary
	import hhs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input hhs_in_t in,
	input logic in_valid,
	output logic in_stall,
	output hhs_out_t out,
	output logic out_valid,
	input logic out_stall
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = 64 + 32 + 3;
	localparam logic [AW:0] LAST = (AW + 1)'(CAPACITY - 1);

	hhs_state_t state_q, state_d;
	logic [6:0] key_limit_q;
	logic [CAPACITY-1:0] live_q;
	logic [31:0] total_q;
	logic [CW-1:0] live_cnt_q;
	hhs_in_t item_q;
	hhs_out_t out_q;
	hhs_out_t res_d;
	logic out_valid_q;
	logic [AW:0] ptr_q;
	logic [AW-1:0] cur_s1;
	logic cur_v_s1;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_cnt_q;
	logic hit_q, free_q;
	logic [6:0] freed_q;
	logic dec_q;
	logic rd_live;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [63:0] r_key;
	logic [31:0] r_cnt;
	logic [2:0] r_type;

	assign r_key = rdata[EW-1 -: 64];
	assign r_cnt = rdata[34:3];
	assign r_type = rdata[2:0];

	hhs_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, key_limit_q} : 32'd0;

	logic [7:0] allowed;
	assign allowed = ({1'b0, key_limit_q} > 8'(CAPACITY)) ? 8'(CAPACITY) : {1'b0, key_limit_q};

	logic has_room;
	assign has_room = 8'(live_cnt_q) < allowed;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out = out_q;
	assign out_valid = out_valid_q;
	assign rd_live = live_q[item_q.entry_index[AW-1:0]];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in.action)
						ACT_ADD: state_d = ST_SCAN;
						ACT_READ: state_d = ST_READ;
						ACT_CLEAR: state_d = ST_CLR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (!cur_v_s1 && ptr_q > LAST) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (!hit_q && !(free_q && has_room)) state_d = ST_DEC;
				else state_d = ST_DONE;
			end
			ST_DEC: begin
				if (!cur_v_s1 && ptr_q > LAST) state_d = ST_DONE;
			end
			ST_READ: state_d = ptr_q[0] ? ST_DONE : ST_READ;
			ST_CLR: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control: scans issue one read per cycle; the write goes to
	// the slot whose read data arrives this cycle (decrement) or to the chosen
	// slot (increment or insert). The hit count is captured during the scan.
	always_comb begin
		we = 1'b0;
		waddr = cur_s1;
		wdata = rdata;
		raddr = ptr_q[AW-1:0];
		case (state_q)
			ST_INS: begin
				if (hit_q) begin
					we = 1'b1;
					waddr = hit_idx_q;
					wdata = {item_q.key, (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + 32'd1,
						item_q.value_type};
				end else if (free_q && has_room) begin
					we = 1'b1;
					waddr = free_idx_q;
					wdata = {item_q.key, 32'd1, item_q.value_type};
				end
			end
			ST_DEC: begin
				if (cur_v_s1 && live_q[cur_s1] && r_cnt > 32'd1) begin
					we = 1'b1;
					wdata = {r_key, r_cnt - 32'd1, r_type};
				end
			end
			ST_READ: raddr = item_q.entry_index[AW-1:0];
			default: ;
		endcase
	end

	always_comb begin
		res_d = '0;
		res_d.total_adds = total_q;
		res_d.occupancy = 7'(live_cnt_q);
		case (item_q.action)
			ACT_ADD: begin
				if (hit_q) begin
					res_d.outcome = OUT_INCR;
				end else if (dec_q) begin
					res_d.outcome = OUT_DECR;
					res_d.freed_entries = freed_q;
				end else begin
					res_d.outcome = OUT_INSERT;
				end
			end
			ACT_READ: begin
				res_d.outcome = OUT_READ;
				if (rd_live) begin
					res_d.entry_valid = 1'b1;
					res_d.entry_key = r_key;
					res_d.entry_count = r_cnt;
					res_d.entry_type = r_type;
				end
			end
			ACT_CLEAR: res_d.outcome = OUT_CLEAR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_limit_q <= KEY_LIMIT_RESET;
			live_q <= '0;
			total_q <= '0;
			live_cnt_q <= '0;
			out_valid_q <= 1'b0;
			ptr_q <= '0;
			cur_v_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			hit_cnt_q <= '0;
			freed_q <= '0;
			dec_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready && paddr == 2'd0) begin
				key_limit_q <= pwdata[6:0];
			end
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			cur_v_s1 <= (state_q == ST_SCAN || state_q == ST_DEC) && ptr_q <= LAST;
			case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					dec_q <= 1'b0;
					if (accept && in.action == ACT_ADD && total_q != CNT_MAX) begin
						total_q <= total_q + 32'd1;
					end
				end
				ST_SCAN: begin
					if (ptr_q <= LAST) ptr_q <= ptr_q + 1'b1;
					if (cur_v_s1) begin
						if (live_q[cur_s1] && r_key == item_q.key && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cur_s1;
							hit_cnt_q <= r_cnt;
						end
						if (!live_q[cur_s1] && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= cur_s1;
						end
					end
				end
				ST_INS: begin
					ptr_q <= '0;
					freed_q <= '0;
					if (!hit_q && free_q && has_room) begin
						live_q[free_idx_q] <= 1'b1;
						live_cnt_q <= live_cnt_q + 1'b1;
					end
				end
				ST_DEC: begin
					dec_q <= 1'b1;
					if (ptr_q <= LAST) ptr_q <= ptr_q + 1'b1;
					if (cur_v_s1 && live_q[cur_s1] && r_cnt <= 32'd1) begin
						live_q[cur_s1] <= 1'b0;
						freed_q <= freed_q + 7'd1;
						if (live_cnt_q != '0) live_cnt_q <= live_cnt_q - 1'b1;
					end
				end
				ST_READ: ptr_q <= ptr_q + 1'b1;
				ST_CLR: begin
					live_q <= '0;
					total_q <= '0;
					live_cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= in;
		cur_s1 <= ptr_q[AW-1:0];
		if (state_q == ST_DONE) out_q <= res_d;
	end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top
	import hhs_pkg::*;
();

	localparam int SLOTS = CAPACITY;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	hhs_in_t in;
	logic in_valid;
	logic in_stall;
	hhs_out_t out;
	logic out_valid;
	logic out_stall;

	heavy_hitter_summary dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in(in), .in_valid(in_valid), .in_stall(in_stall),
		.out(out), .out_valid(out_valid), .out_stall(out_stall)
	);

	// Shadow copy of the summary table.
	logic summ_live [SLOTS];
	logic [63:0] summ_key [SLOTS];
	logic [31:0] summ_count [SLOTS];
	logic [2:0] summ_type [SLOTS];
	logic [31:0] summ_total;
	logic [6:0] summ_used;
	logic [6:0] summ_limit;

	hhs_in_t pending_beats[$];
	hhs_out_t expected_results[$];
	int mismatches;
	int checked;
	int decrements;
	longint cycles;
	bit quiet_drive;
	bit quiet_sink;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_summary();
		for (int i = 0; i < SLOTS; i++) begin
			summ_live[i] = 1'b0;
			summ_count[i] = '0;
		end
		summ_total = '0;
		summ_used = '0;
	endfunction

	// Applies one action to the shadow table and queues the result it causes.
	function automatic void predict_summary(hhs_in_t b);
		hhs_out_t r;
		bit done;
		int room;
		r = '0;
		done = 0;
		room = (summ_limit > SLOTS) ? SLOTS : summ_limit;
		if (b.action == ACT_NONE)
			return;
		if (b.action == ACT_ADD) begin
			if (summ_total != CNT_MAX)
				summ_total++;
			for (int i = 0; i < SLOTS && !done; i++) begin
				if (summ_live[i] && summ_key[i] == b.key) begin
					if (summ_count[i] != CNT_MAX)
						summ_count[i]++;
					summ_type[i] = b.value_type;
					r.outcome = OUT_INCR;
					done = 1;
				end
			end
			if (!done && summ_used < room) begin
				for (int i = 0; i < SLOTS && !done; i++) begin
					if (!summ_live[i]) begin
						summ_live[i] = 1'b1;
						summ_key[i] = b.key;
						summ_count[i] = 32'd1;
						summ_type[i] = b.value_type;
						summ_used++;
						r.outcome = OUT_INSERT;
						done = 1;
					end
				end
			end
			if (!done) begin
				r.outcome = OUT_DECR;
				for (int i = 0; i < SLOTS; i++) begin
					if (summ_live[i]) begin
						if (summ_count[i] <= 1) begin
							summ_live[i] = 1'b0;
							summ_count[i] = '0;
							r.freed_entries++;
							if (summ_used > 0)
								summ_used--;
						end else begin
							summ_count[i]--;
						end
					end
				end
			end
		end else if (b.action == ACT_READ) begin
			r.outcome = OUT_READ;
			if (summ_live[b.entry_index]) begin
				r.entry_valid = 1'b1;
				r.entry_key = summ_key[b.entry_index];
				r.entry_count = summ_count[b.entry_index];
				r.entry_type = summ_type[b.entry_index];
			end
		end else begin
			r.outcome = OUT_CLEAR;
			clear_summary();
		end
		r.total_adds = summ_total;
		r.occupancy = summ_used;
		expected_results.push_back(r);
	endfunction

	function automatic hhs_in_t make_beat(logic [1:0] act, logic [63:0] k,
			logic [2:0] vt, logic [5:0] idx);
		hhs_in_t b;
		b.action = act;
		b.key = k;
		b.value_type = vt;
		b.entry_index = idx;
		return b;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Driver: presents the next queued beat, predicting it when it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_summary(in);
				void'(pending_beats.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (pending_beats.size() > 0
					&& (quiet_drive || $urandom_range(99) >= 9)) begin
				in <= pending_beats[0];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", out);
				end else begin
					hhs_out_t e;
					e = expected_results.pop_front();
					checked++;
					if (e.outcome == OUT_DECR)
						decrements++;
					if (out !== e) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d differs", checked);
							$display("  expected %p", e);
							$display("  actual   %p", out);
						end
					end
				end
			end
			out_stall <= !quiet_sink && ($urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic apb_write(logic [6:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {25'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		summ_limit = v;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		// An undefined action leaves no result and does not hold the block.
		repeat (2 * SLOTS + 10) @(posedge clk);
	endtask

	// Random adds, mostly from a small hot set, with reads, a rare clear and a rare undefined action.
	task automatic queue_random(int n, int hot);
		logic [63:0] hot_keys [8];
		int pick;
		for (int i = 0; i < 8; i++)
			hot_keys[i] = rand_key();
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 60)
				pending_beats.push_back(make_beat(ACT_ADD,
					hot_keys[$urandom_range(hot - 1)], 3'($urandom), 6'($urandom)));
			else if (pick < 78)
				pending_beats.push_back(make_beat(ACT_ADD, rand_key(),
					3'($urandom), 6'($urandom)));
			else if (pick < 96)
				pending_beats.push_back(make_beat(ACT_READ, rand_key(),
					3'($urandom), 6'($urandom)));
			else if (pick < 98)
				pending_beats.push_back(make_beat(ACT_CLEAR, rand_key(),
					3'($urandom), 6'($urandom)));
			else
				pending_beats.push_back(make_beat(ACT_NONE, rand_key(),
					3'($urandom), 6'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		checked = 0;
		decrements = 0;
		cycles = 0;
		quiet_drive = 1'b0;
		quiet_sink = 1'b0;
		summ_limit = KEY_LIMIT_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			summ_key[i] = '0;
			summ_type[i] = '0;
		end
		clear_summary();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of fields, every action, undefined action, reads of
		// empty and live slots, then decrement-all with a limit of two.
		pending_beats.push_back(make_beat(ACT_READ, '0, '0, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, '1, 3'd7, 6'd63));
		pending_beats.push_back(make_beat(ACT_ADD, '0, 3'd0, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, '1, 3'd3, 6'd0));
		pending_beats.push_back(make_beat(ACT_NONE, '1, 3'd7, 6'd63));
		pending_beats.push_back(make_beat(ACT_READ, '1, 3'd7, 6'd0));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd1));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd63));
		pending_beats.push_back(make_beat(ACT_CLEAR, '1, 3'd7, 6'd63));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd0));
		wait_drained();

		apb_write(7'd2);
		pending_beats.push_back(make_beat(ACT_ADD, 64'hA5A5, 3'd1, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, 64'hA5A5, 3'd2, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, 64'h5A5A, 3'd4, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, 64'h1234, 3'd5, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, 64'h9999, 3'd6, 6'd0));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd0));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd1));
		wait_drained();

		// Zero limit: every miss decrements, and lowering below occupancy keeps entries.
		apb_write(7'd0);
		pending_beats.push_back(make_beat(ACT_ADD, 64'hA5A5, 3'd0, 6'd0));
		pending_beats.push_back(make_beat(ACT_ADD, 64'h7777, 3'd0, 6'd0));
		pending_beats.push_back(make_beat(ACT_READ, '0, 3'd0, 6'd0));
		wait_drained();

		// Random phases across limits from 1 up to the maximum of 127. The first runs
		// with no idling on either side.
		quiet_drive = 1'b1;
		quiet_sink = 1'b1;
		apb_write(7'd4);
		queue_random(150, 6);
		wait_drained();
		quiet_drive = 1'b0;
		quiet_sink = 1'b0;

		apb_write(7'd1);
		queue_random(120, 2);
		wait_drained();

		apb_write(7'd127);
		queue_random(180, 8);
		wait_drained();

		apb_write(7'd64);
		queue_random(150, 8);
		wait_drained();

		apb_write(7'd3);
		queue_random(200, 5);
		wait_drained();

		$display("%0d results checked over limits 0 to 127, %0d decrement-all steps",
			checked, decrements);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
